### src/tkdb_pkg.sv
`default_nettype none

package tkdb_pkg;

  localparam int unsigned NumKeys  = 3;
  localparam int unsigned MaxKeys  = 3;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned DebW     = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned KeyCodeW = 2;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CmdW-1:0] CmdTick      = 2'd0;
  localparam logic [CmdW-1:0] CmdReadShort = 2'd1;
  localparam logic [CmdW-1:0] CmdReadLong  = 2'd2;

  localparam logic [PhaseW-1:0] PhIdle      = 2'd0;
  localparam logic [PhaseW-1:0] PhPressDb   = 2'd1;
  localparam logic [PhaseW-1:0] PhHeld      = 2'd2;
  localparam logic [PhaseW-1:0] PhReleaseDb = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 1'b1;

  localparam logic [DebW-1:0]  DebounceReset  = 8'd2;
  localparam logic [HoldW-1:0] LongPressReset = 16'd200;

  localparam logic [KeyCodeW-1:0] KeyCodeNone = 2'd0;
  localparam logic [KeyCodeW-1:0] KeyCodeLong = 2'd3;

  typedef struct packed {
    logic tick;
    logic level;
    logic clear_long;
  } key_ctrl_t;

  typedef struct packed {
    logic short_hit;
    logic long_flag;
    logic long_next;
  } key_status_t;

endpackage

`default_nettype wire

### src/tkdb_if.sv
`default_nettype none

interface tkdb_in_if;
  logic                        valid;
  logic                        ready;
  logic [tkdb_pkg::CmdW-1:0]   command;
  logic                        key1_level;
  logic                        key2_level;
  logic                        key3_level;

  modport source (output valid, command, key1_level, key2_level, key3_level, input ready);
  modport sink   (input valid, command, key1_level, key2_level, key3_level, output ready);
endinterface

interface tkdb_out_if;
  logic                            valid;
  logic                            ready;
  logic [tkdb_pkg::KeyCodeW-1:0]   key_code;
  logic                            short_waiting;
  logic                            long_waiting;

  modport source (output valid, key_code, short_waiting, long_waiting, input ready);
  modport sink   (input valid, key_code, short_waiting, long_waiting, output ready);
endinterface

interface tkdb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tkdb_pkg::CfgIdxW-1:0]    index;
  logic [tkdb_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/tkdb_key.sv
`default_nettype none

module tkdb_key (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tkdb_pkg::key_ctrl_t          ctrl_i,
  input  wire logic [tkdb_pkg::DebW-1:0]    debounce_ticks_i,
  input  wire logic [tkdb_pkg::HoldW-1:0]   long_press_ticks_i,
  output tkdb_pkg::key_status_t             status_o
);

  logic [tkdb_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [tkdb_pkg::DebW-1:0]   deb_cnt_q, deb_cnt_d, deb_inc;
  logic [tkdb_pkg::HoldW-1:0]  hold_cnt_q, hold_cnt_d, hold_inc;
  logic                        long_flag_q, long_flag_d;
  logic                        handled_q, handled_d;
  logic                        short_hit;

  assign deb_inc  = deb_cnt_q + 1'b1;
  assign hold_inc = hold_cnt_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    deb_cnt_d   = deb_cnt_q;
    hold_cnt_d  = hold_cnt_q;
    long_flag_d = long_flag_q;
    handled_d   = handled_q;
    short_hit   = 1'b0;
    if (ctrl_i.tick) begin
      unique case (phase_q)
        tkdb_pkg::PhIdle: begin
          if (!ctrl_i.level) begin
            phase_d     = tkdb_pkg::PhPressDb;
            deb_cnt_d   = '0;
            hold_cnt_d  = '0;
            long_flag_d = 1'b0;
            handled_d   = 1'b0;
          end
        end
        tkdb_pkg::PhPressDb: begin
          if (deb_inc >= debounce_ticks_i) begin
            phase_d   = ctrl_i.level ? tkdb_pkg::PhIdle : tkdb_pkg::PhHeld;
            deb_cnt_d = '0;
          end else begin
            deb_cnt_d = deb_inc;
          end
        end
        tkdb_pkg::PhHeld: begin
          if (!ctrl_i.level) begin
            if (!handled_q) begin
              if (hold_inc >= long_press_ticks_i) begin
                long_flag_d = 1'b1;
                handled_d   = 1'b1;
                hold_cnt_d  = '0;
              end else begin
                hold_cnt_d = hold_inc;
              end
            end
          end else begin
            phase_d   = tkdb_pkg::PhReleaseDb;
            deb_cnt_d = '0;
          end
        end
        tkdb_pkg::PhReleaseDb: begin
          if (deb_inc >= debounce_ticks_i) begin
            short_hit  = ctrl_i.level && !long_flag_q;
            phase_d    = tkdb_pkg::PhIdle;
            deb_cnt_d  = '0;
            hold_cnt_d = '0;
            handled_d  = 1'b0;
          end else begin
            deb_cnt_d = deb_inc;
          end
        end
      endcase
    end
    if (ctrl_i.clear_long) begin
      long_flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tkdb_pkg::PhIdle;
      deb_cnt_q   <= '0;
      hold_cnt_q  <= '0;
      long_flag_q <= 1'b0;
      handled_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      deb_cnt_q   <= deb_cnt_d;
      hold_cnt_q  <= hold_cnt_d;
      long_flag_q <= long_flag_d;
      handled_q   <= handled_d;
    end
  end

  assign status_o.short_hit = short_hit;
  assign status_o.long_flag = long_flag_q;
  assign status_o.long_next = long_flag_d;

endmodule

`default_nettype wire

### src/three_key_debounce_long_press.sv
`default_nettype none

// port      dir  beat contents
// item_i    in   command, key1_level, key2_level, key3_level
// result_o  out  key_code, short_waiting, long_waiting
// cfg_i     in   index (0 debounce_ticks, 1 long_press_ticks), data
//
// one beat per cycle sustained while result_o.ready is high; a taken beat goes
// through the input register, then the key update into the result register
// reset returns every key to idle and the registers to 2 and 200
// a stalled result holds the result register and the input register;
// item_i.ready is high while the input register is empty or is advancing

module three_key_debounce_long_press #(
  parameter int unsigned NUM_KEYS = tkdb_pkg::NumKeys
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tkdb_in_if.sink     item_i,
  tkdb_out_if.source  result_o,
  tkdb_cfg_if.sink    cfg_i
);

  logic [tkdb_pkg::DebW-1:0]  debounce_ticks_q;
  logic [tkdb_pkg::HoldW-1:0] long_press_ticks_q;

  logic                        in_vld_q;
  logic [tkdb_pkg::CmdW-1:0]   cmd_q;
  logic [tkdb_pkg::MaxKeys-1:0] level_q;

  logic                          out_vld_q;
  logic [tkdb_pkg::KeyCodeW-1:0] key_code_q, key_code_d;
  logic                          short_out_q;
  logic                          long_out_q;

  logic                          short_ready_q, short_ready_d;
  logic [tkdb_pkg::KeyCodeW-1:0] short_code_q, short_code_d;

  logic advance;
  logic tick;
  logic clear_long;
  logic long3_q;
  logic long3_next;

  tkdb_pkg::key_status_t key_status [NUM_KEYS];

  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || advance;
  assign tick         = advance && (cmd_q == tkdb_pkg::CmdTick);
  assign cfg_i.ready  = 1'b1;

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
    tkdb_pkg::key_ctrl_t ctrl;
    assign ctrl.tick       = tick;
    assign ctrl.level      = level_q[g];
    assign ctrl.clear_long = (g == tkdb_pkg::MaxKeys - 1) ? clear_long : 1'b0;

    tkdb_key u_key (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .ctrl_i             (ctrl),
      .debounce_ticks_i   (debounce_ticks_q),
      .long_press_ticks_i (long_press_ticks_q),
      .status_o           (key_status[g])
    );
  end

  if (NUM_KEYS >= tkdb_pkg::MaxKeys) begin : g_key3
    assign long3_q    = key_status[tkdb_pkg::MaxKeys-1].long_flag;
    assign long3_next = key_status[tkdb_pkg::MaxKeys-1].long_next;
  end else begin : g_no_key3
    assign long3_q    = 1'b0;
    assign long3_next = 1'b0;
  end

  always_comb begin
    short_ready_d = short_ready_q;
    short_code_d  = short_code_q;
    key_code_d    = tkdb_pkg::KeyCodeNone;
    clear_long    = 1'b0;
    if (advance) begin
      unique case (cmd_q)
        tkdb_pkg::CmdTick: begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (key_status[i].short_hit) begin
              short_ready_d = 1'b1;
              short_code_d  = tkdb_pkg::KeyCodeW'(i + 1);
            end
          end
        end
        tkdb_pkg::CmdReadShort: begin
          if (short_ready_q) begin
            key_code_d    = short_code_q;
            short_ready_d = 1'b0;
            short_code_d  = tkdb_pkg::KeyCodeNone;
          end
        end
        tkdb_pkg::CmdReadLong: begin
          if (long3_q) begin
            key_code_d = tkdb_pkg::KeyCodeLong;
            clear_long = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q           <= 1'b0;
      out_vld_q          <= 1'b0;
      short_ready_q      <= 1'b0;
      short_code_q       <= tkdb_pkg::KeyCodeNone;
      debounce_ticks_q   <= tkdb_pkg::DebounceReset;
      long_press_ticks_q <= tkdb_pkg::LongPressReset;
    end else begin
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      short_ready_q <= short_ready_d;
      short_code_q  <= short_code_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          tkdb_pkg::CfgDebounce:  debounce_ticks_q   <= cfg_i.data[tkdb_pkg::DebW-1:0];
          tkdb_pkg::CfgLongPress: long_press_ticks_q <= cfg_i.data[tkdb_pkg::HoldW-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      cmd_q   <= item_i.command;
      level_q <= {item_i.key3_level, item_i.key2_level, item_i.key1_level};
    end
    if (advance) begin
      key_code_q  <= key_code_d;
      short_out_q <= short_ready_d;
      long_out_q  <= long3_next;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.key_code      = key_code_q;
  assign result_o.short_waiting = short_out_q;
  assign result_o.long_waiting  = long_out_q;

  a_tick_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> (result_o.key_code == tkdb_pkg::KeyCodeNone))
    else $error("tick beat returned a key code");

  a_short_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (result_o.short_waiting == short_ready_q))
    else $error("short_waiting differs from pending short state");

  a_long_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (result_o.long_waiting == long3_q))
    else $error("long_waiting differs from key 3 long flag");

endmodule

`default_nettype wire

### test/tb_three_key_debounce_long_press.sv
`default_nettype none

module tb_three_key_debounce_long_press;
  timeunit 1ns;
  timeprecision 1ps;

  import tkdb_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic [KeyCodeW-1:0] key_code;
    logic                short_waiting;
    logic                long_waiting;
  } key_status_beat_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [2:0]       levels;
    bit               typed;
    key_status_beat_t want;
  } script_row_t;

  localparam key_status_beat_t Quiet = '{KeyCodeNone, 1'b0, 1'b0};

  // levels are {key3, key2, key1}, 0 means pressed
  script_row_t opening_script [24] = '{
    '{CmdReadShort, 3'b111, 1'b1, Quiet},
    '{CmdReadLong,  3'b111, 1'b1, Quiet},
    '{CmdUnused,    3'b000, 1'b1, Quiet},
    '{CmdTick,      3'b111, 1'b1, Quiet},
    '{CmdTick,      3'b110, 1'b0, Quiet},
    '{CmdTick,      3'b110, 1'b0, Quiet},
    '{CmdTick,      3'b110, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdReadShort, 3'b111, 1'b0, Quiet},
    '{CmdReadShort, 3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b001, 1'b0, Quiet},
    '{CmdTick,      3'b001, 1'b0, Quiet},
    '{CmdTick,      3'b001, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdUnused,    3'b111, 1'b0, Quiet},
    '{CmdReadShort, 3'b000, 1'b0, Quiet},
    '{CmdTick,      3'b110, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdTick,      3'b111, 1'b0, Quiet},
    '{CmdReadShort, 3'b111, 1'b0, Quiet}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tkdb_in_if  item_if ();
  tkdb_out_if result_if ();
  tkdb_cfg_if cfg_if ();

  three_key_debounce_long_press #(
    .NUM_KEYS(NumKeys)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // key model state
  logic [PhaseW-1:0] key_phase [MaxKeys];
  logic [DebW-1:0]   bounce_cnt [MaxKeys];
  logic [HoldW-1:0]  held_cnt [MaxKeys];
  bit                long_seen [MaxKeys];
  bit                long_spent [MaxKeys];
  bit                short_pending;
  logic [KeyCodeW-1:0] short_key;
  logic [DebW-1:0]   debounce_limit;
  logic [HoldW-1:0]  long_limit;

  key_status_beat_t expected_status [$];
  int unsigned      mismatches;
  int unsigned      idle_pct;
  bit               calm;

  // random press pattern per key
  bit finger_up [MaxKeys];
  int finger_left [MaxKeys];

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void step_key(input int k, input logic lvl);
    case (key_phase[k])
      PhIdle: begin
        if (!lvl) begin
          key_phase[k]  = PhPressDb;
          bounce_cnt[k] = '0;
          held_cnt[k]   = '0;
          long_seen[k]  = 1'b0;
          long_spent[k] = 1'b0;
        end
      end
      PhPressDb: begin
        bounce_cnt[k] = bounce_cnt[k] + 1'b1;
        if (bounce_cnt[k] >= debounce_limit) begin
          key_phase[k]  = lvl ? PhIdle : PhHeld;
          bounce_cnt[k] = '0;
        end
      end
      PhHeld: begin
        if (!lvl) begin
          if (!long_spent[k]) begin
            held_cnt[k] = held_cnt[k] + 1'b1;
            if (held_cnt[k] >= long_limit) begin
              long_seen[k]  = 1'b1;
              long_spent[k] = 1'b1;
              held_cnt[k]   = '0;
            end
          end
        end else begin
          key_phase[k]  = PhReleaseDb;
          bounce_cnt[k] = '0;
        end
      end
      default: begin
        bounce_cnt[k] = bounce_cnt[k] + 1'b1;
        if (bounce_cnt[k] >= debounce_limit) begin
          if (lvl && !long_seen[k]) begin
            short_pending = 1'b1;
            short_key     = KeyCodeW'(k + 1);
          end
          key_phase[k]  = PhIdle;
          bounce_cnt[k] = '0;
          held_cnt[k]   = '0;
          long_spent[k] = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic key_status_beat_t predict_keys(input logic [CmdW-1:0] cmd,
                                                    input logic [2:0] levels);
    key_status_beat_t r;
    r = Quiet;
    case (cmd)
      CmdTick: begin
        for (int k = 0; k < NumKeys; k++) step_key(k, levels[k]);
      end
      CmdReadShort: begin
        if (short_pending) begin
          r.key_code    = short_key;
          short_pending = 1'b0;
          short_key     = KeyCodeNone;
        end
      end
      CmdReadLong: begin
        if (NumKeys >= 3 && long_seen[2]) begin
          long_seen[2] = 1'b0;
          r.key_code   = KeyCodeLong;
        end
      end
      default: ;
    endcase
    r.short_waiting = short_pending;
    r.long_waiting  = (NumKeys >= 3) && long_seen[2];
    return r;
  endfunction

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [2:0] levels,
                           input bit typed, input key_status_beat_t want);
    key_status_beat_t got;
    @(negedge clk_i);
    item_if.valid      <= 1'b1;
    item_if.command    <= cmd;
    item_if.key1_level <= levels[0];
    item_if.key2_level <= levels[1];
    item_if.key3_level <= levels[2];
    do @(posedge clk_i); while (!item_if.ready);
    got = predict_keys(cmd, levels);
    expected_status.push_back(typed ? want : got);
    if (!calm && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat ($urandom_range(17)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgDebounce) debounce_limit = data[DebW-1:0];
    else long_limit = data[HoldW-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_run(input int n);
    logic [CmdW-1:0] cmd;
    logic [2:0]      levels;
    int              r;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      cmd = (r < 8) ? CmdReadShort : (r < 16) ? CmdReadLong : (r < 19) ? CmdUnused : CmdTick;
      if (cmd == CmdTick) begin
        for (int k = 0; k < MaxKeys; k++) begin
          if (finger_left[k] <= 0) begin
            finger_up[k] = ~finger_up[k];
            if (finger_up[k]) begin
              finger_left[k] = $urandom_range(3 * int'(debounce_limit) + 6);
            end else if ($urandom_range(2) == 0) begin
              finger_left[k] = int'(long_limit) + int'(debounce_limit) + 2 + $urandom_range(8);
            end else begin
              finger_left[k] = $urandom_range(3 * int'(debounce_limit) + 3);
            end
          end else begin
            finger_left[k]--;
          end
          // occasional contact bounce
          levels[k] = finger_up[k] ^ ($urandom_range(19) == 0);
        end
      end else begin
        levels = 3'($urandom);
      end
      send_item(cmd, levels, 1'b0, Quiet);
    end
  endtask

  // result side stalls
  initial begin
    result_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(99) < idle_pct) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    key_status_beat_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_status.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = expected_status.pop_front();
        if (result_if.key_code !== want.key_code)
          flag_mismatch($sformatf("key_code %0d, want %0d", result_if.key_code, want.key_code));
        if (result_if.short_waiting !== want.short_waiting)
          flag_mismatch($sformatf("short_waiting %b, want %b", result_if.short_waiting,
                                  want.short_waiting));
        if (result_if.long_waiting !== want.long_waiting)
          flag_mismatch($sformatf("long_waiting %b, want %b", result_if.long_waiting,
                                  want.long_waiting));
      end
    end
  end

  initial begin
    #(150_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    item_if.valid      = 1'b0;
    item_if.command    = CmdTick;
    item_if.key1_level = 1'b1;
    item_if.key2_level = 1'b1;
    item_if.key3_level = 1'b1;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CfgDebounce;
    cfg_if.data        = '0;
    mismatches         = 0;
    idle_pct           = 25;
    calm               = 1'b0;
    debounce_limit     = DebounceReset;
    long_limit         = LongPressReset;
    short_pending      = 1'b0;
    short_key          = KeyCodeNone;
    for (int k = 0; k < MaxKeys; k++) begin
      key_phase[k]   = PhIdle;
      bounce_cnt[k]  = '0;
      held_cnt[k]    = '0;
      long_seen[k]   = 1'b0;
      long_spent[k]  = 1'b0;
      finger_up[k]   = 1'b1;
      finger_left[k] = 0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening_script[i])
      send_item(opening_script[i].cmd, opening_script[i].levels, opening_script[i].typed,
                opening_script[i].want);
    random_run(130);

    // zero debounce and zero long press
    drain();
    idle_pct = 10;
    write_reg(CfgDebounce, 16'd0);
    write_reg(CfgLongPress, 16'd0);
    random_run(100);

    drain();
    idle_pct = 40;
    write_reg(CfgDebounce, 16'd1);
    write_reg(CfgLongPress, 16'd1);
    random_run(100);

    drain();
    idle_pct = 15;
    write_reg(CfgDebounce, 16'($urandom_range(6, 2)));
    write_reg(CfgLongPress, 16'($urandom_range(30, 3)));
    random_run(160);

    // widest counts: new presses stay in debounce, no new press is flagged
    drain();
    idle_pct = 1;
    write_reg(CfgDebounce, 16'd255);
    write_reg(CfgLongPress, 16'hFFFF);
    for (int i = 0; i < 40; i++) send_item(CmdTick, 3'b010, 1'b0, Quiet);
    send_item(CmdReadLong, 3'b010, 1'b0, Quiet);
    for (int i = 0; i < 10; i++) send_item(CmdTick, 3'b111, 1'b0, Quiet);
    send_item(CmdReadShort, 3'b111, 1'b0, Quiet);
    send_item(CmdReadLong, 3'b111, 1'b0, Quiet);

    drain();
    calm = 1'b1;
    write_reg(CfgDebounce, 16'd3);
    write_reg(CfgLongPress, 16'd12);
    random_run(160);

    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
